[design/vertex_normal_accumulator_macros.svh]
// Assertion macros for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define VNA_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("vna assertion failed");
`define VNA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("vna assertion failed");
`else
`define VNA_ASSERT_IMPL(label, pre, post)
`define VNA_ASSERT_NEXT(label, pre, post)
`endif
`endif

[design/vna_pkg.sv]
// Shared types and constants of the vertex normal accumulator.
`default_nettype none
package vna_pkg;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int ACC_BITS_DEF = 48;

  localparam int IDX_BITS = 10;
  localparam int NV_BITS = 11;
  localparam logic [NV_BITS-1:0] NV_RESET = 11'd1024;
  localparam int FLD_BITS = 16;

  localparam int MAG_BITS = 31;
  localparam int SQ_BITS = 2 * MAG_BITS;
  localparam int SUM_BITS = 64;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS = ROOT_BITS + 4;
  localparam int FRAC_BITS = 16;
  localparam int NUM_BITS = MAG_BITS + FRAC_BITS + 1;
  localparam int DEN_BITS = ROOT_BITS + 1;
  localparam int QUO_BITS = FRAC_BITS + 1;
  localparam logic [QUO_BITS-1:0] QUO_MAX = 17'd32767;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [IDX_BITS-1:0]        vertex_index;
    logic signed [FLD_BITS-1:0] pos_x;
    logic signed [FLD_BITS-1:0] pos_y;
    logic signed [FLD_BITS-1:0] pos_z;
    logic [IDX_BITS-1:0]        corner_a;
    logic [IDX_BITS-1:0]        corner_b;
    logic [IDX_BITS-1:0]        corner_c;
  } vna_in_t;

  typedef struct packed {
    logic signed [FLD_BITS-1:0] normal_x;
    logic signed [FLD_BITS-1:0] normal_y;
    logic signed [FLD_BITS-1:0] normal_z;
    logic [IDX_BITS-1:0]        read_vertex;
    logic [1:0]                 status;
  } vna_out_t;
endpackage
`default_nettype wire

[design/vertex_normal_accumulator.sv]
// Top level: position and accumulator memories with the request sequencer.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    vna_in_t
//   out_     output     valid / stall    vna_out_t
//   cfg_     input      write enable     num_vertices
//
// One request at a time. Triangle timing is set by one position read port,
// one shared multiplier and three accumulator read-modify-writes on one
// port. A read runs through the shift, square-root and three 17-step
// divide iterations.
// After reset and on a clear request the accumulator memory is swept, one
// entry per cycle across all MAX_VERTICES entries, with in_stall high.
// A result waits in the output register while out_stall is high.
`default_nettype none
`include "vertex_normal_accumulator_macros.svh"
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
  parameter int ACC_BITS     = vna_pkg::ACC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vna_pkg::vna_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vna_pkg::vna_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [vna_pkg::NV_BITS-1:0]  cfg_wdata
);
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int LW0 = $clog2(MAX_VERTICES + 1);
  localparam int LW  = (LW0 > vna_pkg::NV_BITS) ? LW0 : vna_pkg::NV_BITS;
  localparam int CB  = COORD_BITS;
  localparam int EB  = CB + 1;
  localparam int PB  = 2 * EB;
  localparam int FB  = PB + 1;
  localparam int SW  = ((ACC_BITS > FB) ? ACC_BITS : FB) + 1;
  localparam int PWW = 3 * CB;
  localparam int AWW = 3 * ACC_BITS;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VERTICES - 1);
  localparam logic [LW-1:0] MAX_LIM  = LW'(MAX_VERTICES);
  localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_DISP  = 11'b000_0000_0100,
    S_PRD   = 11'b000_0000_1000,
    S_CROSS = 11'b000_0001_0000,
    S_ARD   = 11'b000_0010_0000,
    S_AWR   = 11'b000_0100_0000,
    S_NRD   = 11'b000_1000_0000,
    S_NCHK  = 11'b001_0000_0000,
    S_NWAIT = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [FB-1:0]       f
  );
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(f);
    if (s > SW'(ACC_HI)) begin
      sat_add = ACC_HI;
    end else if (s < SW'(ACC_LO)) begin
      sat_add = ACC_LO;
    end else begin
      sat_add = ACC_BITS'(s);
    end
  endfunction

  logic [PWW-1:0] pos_mem [MAX_VERTICES];
  logic [AWW-1:0] acc_mem [MAX_VERTICES];

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  vna_pkg::vna_in_t item_r, item_nxt;
  logic [vna_pkg::NV_BITS-1:0] nv_r, nv_nxt;
  logic [AW-1:0] clr_ptr_r, clr_ptr_nxt;
  logic signed [CB-1:0] pax_r, pax_nxt, pay_r, pay_nxt, paz_r, paz_nxt;
  logic signed [EB-1:0] e1x_r, e1x_nxt, e1y_r, e1y_nxt, e1z_r, e1z_nxt;
  logic signed [EB-1:0] e2x_r, e2x_nxt, e2y_r, e2y_nxt, e2z_r, e2z_nxt;
  logic signed [PB-1:0] prod_r, prod_nxt;
  logic signed [FB-1:0] fx_r, fx_nxt, fy_r, fy_nxt, fz_r, fz_nxt;
  vna_pkg::vna_out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  vna_pkg::vna_out_t out_data_r, out_data_nxt;
  logic [PWW-1:0] pos_rd_r;
  logic [AWW-1:0] acc_rd_r;

  logic           pos_we, acc_we;
  logic [AW-1:0]  pos_waddr, pos_raddr, acc_addr;
  logic [PWW-1:0] pos_wdata;
  logic [AWW-1:0] acc_wdata;
  logic [vna_pkg::IDX_BITS-1:0] cur_corner;
  logic [LW-1:0] nv_ext, lim;
  logic ok_v, ok_a, ok_b, ok_c;
  logic signed [CB-1:0] prd_x, prd_y, prd_z;
  logic signed [ACC_BITS-1:0] acc_x, acc_y, acc_z;
  logic signed [EB-1:0] mul_a, mul_b;
  logic [2:0] kp;
  logic norm_start, norm_done;
  logic signed [vna_pkg::FLD_BITS-1:0] norm_x, norm_y, norm_z;

  vna_normalize #(.ACC_BITS(ACC_BITS)) u_normalize (
    .clk(clk), .rst_n(rst_n), .start(norm_start),
    .vx(acc_x), .vy(acc_y), .vz(acc_z),
    .done(norm_done), .nx(norm_x), .ny(norm_y), .nz(norm_z)
  );

  always_comb begin
    prd_x  = $signed(pos_rd_r[PWW-1 -: CB]);
    prd_y  = $signed(pos_rd_r[PWW-CB-1 -: CB]);
    prd_z  = $signed(pos_rd_r[CB-1:0]);
    acc_x  = $signed(acc_rd_r[AWW-1 -: ACC_BITS]);
    acc_y  = $signed(acc_rd_r[AWW-ACC_BITS-1 -: ACC_BITS]);
    acc_z  = $signed(acc_rd_r[ACC_BITS-1:0]);
    nv_ext = LW'(nv_r);
    lim    = (nv_ext < MAX_LIM) ? nv_ext : MAX_LIM;
    ok_v   = LW'(item_r.vertex_index) < lim;
    ok_a   = LW'(item_r.corner_a) < lim;
    ok_b   = LW'(item_r.corner_b) < lim;
    ok_c   = LW'(item_r.corner_c) < lim;
    case (cnt_r)
      3'd0: cur_corner = item_r.corner_a;
      3'd1: cur_corner = item_r.corner_b;
      default: cur_corner = item_r.corner_c;
    endcase
    pos_raddr = AW'(cur_corner);
    pos_waddr = AW'(item_r.vertex_index);
    pos_wdata = {CB'($unsigned(item_r.pos_x)), CB'($unsigned(item_r.pos_y)),
                 CB'($unsigned(item_r.pos_z))};
    if (state_r == S_CLR) begin
      acc_addr = clr_ptr_r;
    end else if (state_r == S_NRD || state_r == S_NCHK) begin
      acc_addr = AW'(item_r.vertex_index);
    end else begin
      acc_addr = AW'(cur_corner);
    end
    if (state_r == S_CLR) begin
      acc_wdata = '0;
    end else begin
      acc_wdata = {sat_add(acc_x, fx_r), sat_add(acc_y, fy_r), sat_add(acc_z, fz_r)};
    end
    case (cnt_r)
      3'd0: begin
        mul_a = e1y_r;
        mul_b = e2z_r;
      end
      3'd1: begin
        mul_a = e1z_r;
        mul_b = e2y_r;
      end
      3'd2: begin
        mul_a = e1z_r;
        mul_b = e2x_r;
      end
      3'd3: begin
        mul_a = e1x_r;
        mul_b = e2z_r;
      end
      3'd4: begin
        mul_a = e1x_r;
        mul_b = e2y_r;
      end
      default: begin
        mul_a = e1y_r;
        mul_b = e2x_r;
      end
    endcase
    kp = cnt_r - 3'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    nv_nxt        = cfg_we ? cfg_wdata : nv_r;
    clr_ptr_nxt   = clr_ptr_r;
    pax_nxt       = pax_r;
    pay_nxt       = pay_r;
    paz_nxt       = paz_r;
    e1x_nxt       = e1x_r;
    e1y_nxt       = e1y_r;
    e1z_nxt       = e1z_r;
    e2x_nxt       = e2x_r;
    e2y_nxt       = e2y_r;
    e2z_nxt       = e2z_r;
    prod_nxt      = prod_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    fz_nxt        = fz_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    pos_we        = 1'b0;
    acc_we        = 1'b0;
    norm_start    = 1'b0;
    case (state_r)
      S_CLR: begin
        acc_we = 1'b1;
        if (clr_ptr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt        = '0;
        res_nxt.status = vna_pkg::ST_RANGE;
        case (item_r.req_type)
          vna_pkg::REQ_LOAD: begin
            res_nxt.read_vertex = item_r.vertex_index;
            if (ok_v) begin
              pos_we    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          vna_pkg::REQ_TRI: begin
            cnt_nxt = 3'd0;
            if (!ok_a) begin
              res_nxt.read_vertex = item_r.corner_a;
              state_nxt = S_DONE;
            end else if (!ok_b) begin
              res_nxt.read_vertex = item_r.corner_b;
              state_nxt = S_DONE;
            end else if (!ok_c) begin
              res_nxt.read_vertex = item_r.corner_c;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_PRD;
            end
          end
          vna_pkg::REQ_READ: begin
            res_nxt.read_vertex = item_r.vertex_index;
            state_nxt = ok_v ? S_NRD : S_DONE;
          end
          vna_pkg::REQ_CLEAR: begin
            clr_ptr_nxt = '0;
            state_nxt   = S_CLR;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PRD: begin
        cnt_nxt = cnt_r + 3'd1;
        case (cnt_r)
          3'd1: begin
            pax_nxt = prd_x;
            pay_nxt = prd_y;
            paz_nxt = prd_z;
          end
          3'd2: begin
            e1x_nxt = EB'(prd_x) - EB'(pax_r);
            e1y_nxt = EB'(prd_y) - EB'(pay_r);
            e1z_nxt = EB'(prd_z) - EB'(paz_r);
          end
          3'd3: begin
            e2x_nxt   = EB'(prd_x) - EB'(pax_r);
            e2y_nxt   = EB'(prd_y) - EB'(pay_r);
            e2z_nxt   = EB'(prd_z) - EB'(paz_r);
            cnt_nxt   = 3'd0;
            state_nxt = S_CROSS;
          end
          default: ;
        endcase
      end
      S_CROSS: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r != 3'd6) begin
          prod_nxt = PB'(mul_a) * PB'(mul_b);
        end
        if (cnt_r != 3'd0) begin
          case (kp)
            3'd0: fx_nxt = FB'(prod_r);
            3'd1: fx_nxt = fx_r - FB'(prod_r);
            3'd2: fy_nxt = FB'(prod_r);
            3'd3: fy_nxt = fy_r - FB'(prod_r);
            3'd4: fz_nxt = FB'(prod_r);
            default: fz_nxt = fz_r - FB'(prod_r);
          endcase
        end
        if (cnt_r == 3'd6) begin
          cnt_nxt   = 3'd0;
          state_nxt = S_ARD;
        end
      end
      S_ARD: state_nxt = S_AWR;
      S_AWR: begin
        acc_we = 1'b1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = S_ARD;
        end
      end
      S_NRD: state_nxt = S_NCHK;
      S_NCHK: begin
        if (acc_rd_r == '0) begin
          res_nxt             = '0;
          res_nxt.read_vertex = item_r.vertex_index;
          res_nxt.status      = vna_pkg::ST_ZERO;
          state_nxt           = S_DONE;
        end else begin
          norm_start = 1'b1;
          state_nxt  = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (norm_done) begin
          res_nxt.normal_x    = norm_x;
          res_nxt.normal_y    = norm_y;
          res_nxt.normal_z    = norm_z;
          res_nxt.read_vertex = item_r.vertex_index;
          res_nxt.status      = vna_pkg::ST_OK;
          state_nxt           = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= 3'd0;
      nv_r        <= vna_pkg::NV_RESET;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nv_r        <= nv_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pax_r      <= pax_nxt;
    pay_r      <= pay_nxt;
    paz_r      <= paz_nxt;
    e1x_r      <= e1x_nxt;
    e1y_r      <= e1y_nxt;
    e1z_r      <= e1z_nxt;
    e2x_r      <= e2x_nxt;
    e2y_r      <= e2y_nxt;
    e2z_r      <= e2z_nxt;
    prod_r     <= prod_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    fz_r       <= fz_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rd_r <= acc_mem[acc_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VNA_ASSERT_NEXT(a_clr_sweep, state_r == S_CLR && clr_ptr_r != CLR_LAST, state_r == S_CLR && clr_ptr_r == AW'($past(clr_ptr_r) + 1'b1))
  `VNA_ASSERT_IMPL(a_norm_done_wait, norm_done, state_r == S_NWAIT)
  `VNA_ASSERT_IMPL(a_err_zero_normal, out_valid && out_data.status != vna_pkg::ST_OK, out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
endmodule
`default_nettype wire

[design/vna_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module vna_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [vna_pkg::SUM_BITS-1:0]   radicand,
  output logic                           done,
  output logic [vna_pkg::ROOT_BITS-1:0]  root
);
  localparam int SB = vna_pkg::SUM_BITS;
  localparam int RB = vna_pkg::ROOT_BITS;
  localparam int MB = vna_pkg::REM_BITS;
  localparam int CW = $clog2(RB);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0] n_r, n_nxt;
  logic [MB-1:0] rem_r, rem_nxt;
  logic [RB-1:0] root_r, root_nxt;
  logic [MB-1:0] rem_sh;
  logic [MB-1:0] trial;

  always_comb begin
    rem_sh   = {rem_r[MB-3:0], n_r[SB-1 -: 2]};
    trial    = MB'({root_r, 2'b01});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      n_nxt = n_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RB-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(RB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

[design/vna_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vna_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vna_pkg::NUM_BITS-1:0]  num,
  input  logic [vna_pkg::DEN_BITS-1:0]  den,
  output logic                          done,
  output logic [vna_pkg::QUO_BITS-1:0]  quo
);
  localparam int NB = vna_pkg::NUM_BITS;
  localparam int DB = vna_pkg::DEN_BITS;
  localparam int QB = vna_pkg::QUO_BITS;
  localparam int CW = $clog2(QB);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DB-1:0] rem_r, rem_nxt;
  logic [DB-1:0] den_r, den_nxt;
  logic [QB-1:0] bits_r, bits_nxt;
  logic [QB-1:0] quo_r, quo_nxt;
  logic [DB:0]   rem_sh;

  always_comb begin
    rem_sh   = {rem_r, bits_r[QB-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // quotient is known to fit QB bits, so the high part is below den
      rem_nxt  = DB'(num[NB-1:QB]);
      den_nxt  = den;
      bits_nxt = num[QB-1:0];
      quo_nxt  = '0;
    end else if (busy_r) begin
      bits_nxt = bits_r << 1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DB'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = DB'(rem_sh);
        quo_nxt = {quo_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

[design/vna_normalize.sv]
// Scales one accumulated normal to unit length in Q1.15.
`default_nettype none
module vna_normalize #(
  parameter int ACC_BITS = vna_pkg::ACC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ACC_BITS-1:0]           vx,
  input  logic signed [ACC_BITS-1:0]           vy,
  input  logic signed [ACC_BITS-1:0]           vz,
  output logic                                 done,
  output logic signed [vna_pkg::FLD_BITS-1:0]  nx,
  output logic signed [vna_pkg::FLD_BITS-1:0]  ny,
  output logic signed [vna_pkg::FLD_BITS-1:0]  nz
);
  localparam int A  = ACC_BITS;
  localparam int MB = vna_pkg::MAG_BITS;
  localparam int QB = vna_pkg::QUO_BITS;
  localparam int FB = vna_pkg::FLD_BITS;

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_SHIFT = 8'b0000_0010,
    N_MUL   = 8'b0000_0100,
    N_ADD   = 8'b0000_1000,
    N_SQRT  = 8'b0001_0000,
    N_SQW   = 8'b0010_0000,
    N_DIV   = 8'b0100_0000,
    N_DIVW  = 8'b1000_0000
  } nstate_t;

  nstate_t state_r, state_nxt;
  logic    done_r, done_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [A-1:0] mx_r, mx_nxt, my_r, my_nxt, mz_r, mz_nxt, m_r, m_nxt;
  logic [2:0] neg_r, neg_nxt;
  logic [vna_pkg::SQ_BITS-1:0]   prod_r, prod_nxt;
  logic [vna_pkg::SUM_BITS-1:0]  sum_r, sum_nxt;
  logic [vna_pkg::ROOT_BITS-1:0] len_r, len_nxt;
  logic signed [FB-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;

  logic [A-1:0] mag_x, mag_y, mag_z, mag_max, sel_mag;
  logic         sel_neg;
  logic         sq_start, sq_done, dv_start, dv_done;
  logic [vna_pkg::ROOT_BITS-1:0] sq_root;
  logic [vna_pkg::NUM_BITS-1:0]  dv_num;
  logic [vna_pkg::QUO_BITS-1:0]  dv_quo, q_clamp;
  logic [FB-1:0] q16, q_signed;

  vna_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(sum_r), .done(sq_done), .root(sq_root)
  );

  vna_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start),
    .num(dv_num), .den({len_r, 1'b0}), .done(dv_done), .quo(dv_quo)
  );

  always_comb begin
    mag_x   = vx[A-1] ? (~vx + 1'b1) : vx;
    mag_y   = vy[A-1] ? (~vy + 1'b1) : vy;
    mag_z   = vz[A-1] ? (~vz + 1'b1) : vz;
    mag_max = (mag_x > mag_y) ? mag_x : mag_y;
    mag_max = (mag_z > mag_max) ? mag_z : mag_max;
    case (comp_r)
      2'd0: begin
        sel_mag = mx_r;
        sel_neg = neg_r[0];
      end
      2'd1: begin
        sel_mag = my_r;
        sel_neg = neg_r[1];
      end
      default: begin
        sel_mag = mz_r;
        sel_neg = neg_r[2];
      end
    endcase
    dv_num   = vna_pkg::NUM_BITS'({sel_mag[MB-1:0], {vna_pkg::FRAC_BITS{1'b0}}})
             + vna_pkg::NUM_BITS'(len_r);
    q_clamp  = (dv_quo > vna_pkg::QUO_MAX) ? vna_pkg::QUO_MAX : dv_quo;
    q16      = q_clamp[FB-1:0];
    q_signed = sel_neg ? -q16 : q16;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    comp_nxt  = comp_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    mz_nxt    = mz_r;
    m_nxt     = m_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    rz_nxt    = rz_r;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    case (state_r)
      N_IDLE: begin
        if (start) begin
          mx_nxt    = mag_x;
          my_nxt    = mag_y;
          mz_nxt    = mag_z;
          m_nxt     = mag_max;
          neg_nxt   = {vz[A-1], vy[A-1], vx[A-1]};
          state_nxt = N_SHIFT;
        end
      end
      N_SHIFT: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (|m_r[A-1:MB]) begin
          mx_nxt = mx_r >> 1;
          my_nxt = my_r >> 1;
          mz_nxt = mz_r >> 1;
          m_nxt  = m_r >> 1;
        end else if (!m_r[MB-1]) begin
          mx_nxt = mx_r << 1;
          my_nxt = my_r << 1;
          mz_nxt = mz_r << 1;
          m_nxt  = m_r << 1;
        end else begin
          comp_nxt  = 2'd0;
          sum_nxt   = '0;
          state_nxt = N_MUL;
        end
      end
      N_MUL: begin
        prod_nxt  = sel_mag[MB-1:0] * sel_mag[MB-1:0];
        state_nxt = N_ADD;
      end
      N_ADD: begin
        sum_nxt = sum_r + vna_pkg::SUM_BITS'(prod_r);
        if (comp_r == 2'd2) begin
          state_nxt = N_SQRT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = N_MUL;
        end
      end
      N_SQRT: begin
        sq_start  = 1'b1;
        state_nxt = N_SQW;
      end
      N_SQW: begin
        if (sq_done) begin
          len_nxt   = sq_root;
          comp_nxt  = 2'd0;
          state_nxt = N_DIV;
        end
      end
      N_DIV: begin
        dv_start  = 1'b1;
        state_nxt = N_DIVW;
      end
      N_DIVW: begin
        if (dv_done) begin
          case (comp_r)
            2'd0: rx_nxt = q_signed;
            2'd1: ry_nxt = q_signed;
            default: rz_nxt = q_signed;
          endcase
          if (comp_r == 2'd2) begin
            done_nxt  = 1'b1;
            state_nxt = N_IDLE;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = N_DIV;
          end
        end
      end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      comp_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    mz_r   <= mz_nxt;
    m_r    <= m_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    len_r  <= len_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rz_r   <= rz_nxt;
  end

  assign done = done_r;
  assign nx   = rx_r;
  assign ny   = ry_r;
  assign nz   = rz_r;
endmodule
`default_nettype wire

[sim/vertex_normal_accumulator_tb.sv]
// Testbench for vertex_normal_accumulator: random and directed mesh traffic checked against a model.
`timescale 1ns / 1ps

class normal_scoreboard;
  vna_pkg::vna_out_t pending_results[$];
  int error_count;
  logic signed [15:0] pos_mem [0:1023][3];
  logic signed [47:0] acc_mem [0:1023][3];
  int vertex_count;

  function new();
    error_count = 0;
    vertex_count = 1024;
    for (int i = 0; i < 1024; i++)
      for (int k = 0; k < 3; k++) begin
        pos_mem[i][k] = '0;
        acc_mem[i][k] = '0;
      end
  endfunction

  function logic signed [47:0] sat_add(logic signed [47:0] a, longint f);
    longint hi, lo, s;
    hi = (longint'(1) <<< 47) - 1;
    lo = -hi - 1;
    s = longint'(a) + f;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[47:0];
  endfunction

  function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  function vna_pkg::vna_out_t unit_normal(int vi);
    vna_pkg::vna_out_t r;
    longint unsigned mag [3];
    longint unsigned m, len, q;
    longint v;
    int s;
    r = '0;
    r.read_vertex = vi[9:0];
    m = 0;
    for (int k = 0; k < 3; k++) begin
      v = acc_mem[vi][k];
      mag[k] = v < 0 ? -v : v;
      if (mag[k] > m) m = mag[k];
    end
    if (m == 0) begin
      r.status = vna_pkg::ST_ZERO;
      return r;
    end
    s = 0;
    if (m >= (64'd1 << 31)) begin
      while ((m >> s) >= (64'd1 << 31)) s++;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> s;
    end else begin
      while ((m << s) < (64'd1 << 30)) s++;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << s;
    end
    len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 16) + len) / (len << 1);
      if (q > 32767) q = 32767;
      v = acc_mem[vi][k] < 0 ? -longint'(q) : longint'(q);
      if (k == 0) r.normal_x = v[15:0];
      else if (k == 1) r.normal_y = v[15:0];
      else r.normal_z = v[15:0];
    end
    r.status = vna_pkg::ST_OK;
    return r;
  endfunction

  function void note_request(vna_pkg::vna_in_t t);
    vna_pkg::vna_out_t bad;
    int c [3];
    longint e1 [3], e2 [3], f [3];
    bad = '0;
    bad.status = vna_pkg::ST_RANGE;
    case (t.req_type)
      vna_pkg::REQ_LOAD: begin
        if (t.vertex_index >= vertex_count) begin
          bad.read_vertex = t.vertex_index;
          pending_results.push_back(bad);
        end else begin
          pos_mem[t.vertex_index][0] = t.pos_x;
          pos_mem[t.vertex_index][1] = t.pos_y;
          pos_mem[t.vertex_index][2] = t.pos_z;
        end
      end
      vna_pkg::REQ_TRI: begin
        c[0] = t.corner_a; c[1] = t.corner_b; c[2] = t.corner_c;
        for (int k = 0; k < 3; k++)
          if (c[k] >= vertex_count) begin
            bad.read_vertex = c[k][9:0];
            pending_results.push_back(bad);
            return;
          end
        for (int k = 0; k < 3; k++) begin
          e1[k] = longint'(pos_mem[c[1]][k]) - longint'(pos_mem[c[0]][k]);
          e2[k] = longint'(pos_mem[c[2]][k]) - longint'(pos_mem[c[0]][k]);
        end
        f[0] = e1[1] * e2[2] - e1[2] * e2[1];
        f[1] = e1[2] * e2[0] - e1[0] * e2[2];
        f[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            acc_mem[c[j]][k] = sat_add(acc_mem[c[j]][k], f[k]);
      end
      vna_pkg::REQ_READ: begin
        if (t.vertex_index >= vertex_count) begin
          bad.read_vertex = t.vertex_index;
          pending_results.push_back(bad);
        end else pending_results.push_back(unit_normal(t.vertex_index));
      end
      default: begin
        for (int i = 0; i < 1024; i++)
          for (int k = 0; k < 3; k++) acc_mem[i][k] = '0;
      end
    endcase
  endfunction

  function void check_result(vna_pkg::vna_out_t got);
    vna_pkg::vna_out_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_results.pop_front();
    if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
        got.normal_z !== want.normal_z || got.read_vertex !== want.read_vertex ||
        got.status !== want.status) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch: expected n=(%0d,%0d,%0d) v=%0d s=%0d got n=(%0d,%0d,%0d) v=%0d s=%0d",
                 want.normal_x, want.normal_y, want.normal_z, want.read_vertex, want.status,
                 got.normal_x, got.normal_y, got.normal_z, got.read_vertex, got.status);
    end
  endfunction
endclass

module vertex_normal_accumulator_tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  vna_pkg::vna_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  vna_pkg::vna_out_t out_data;
  logic cfg_we = 0;
  logic [vna_pkg::NV_BITS-1:0] cfg_wdata = '0;

  normal_scoreboard board;
  int idle_cycles = 0;
  bit written [0:1023];
  bit hold_off;
  bit random_stall = 0;

  vertex_normal_accumulator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("vertex_normal_accumulator_tb: errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);

  // receiver: random stalls per transaction, or a long hold-off
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (random_stall && out_valid && !out_stall) begin
        w = $urandom_range(0, 19);
        if (w > 0 && $urandom_range(0, 3) != 0) begin
          out_stall <= 1;
          repeat (w - 1) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // valid stays up after a transaction until the next one or an idle gap
  task automatic send(vna_pkg::vna_in_t t, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 19) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_data <= t;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_request(t);
    if (t.req_type == vna_pkg::REQ_LOAD && t.vertex_index < board.vertex_count)
      written[t.vertex_index] = 1;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_count(int n);
    drain();
    cfg_wdata <= n[vna_pkg::NV_BITS-1:0];
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    board.vertex_count = n > 1024 ? 1024 : n;
  endtask

  function automatic vna_pkg::vna_in_t rand_item();
    vna_pkg::vna_in_t t;
    t = '0;
    t.req_type = 2'($urandom_range(0, 3));
    t.vertex_index = 10'($urandom);
    t.pos_x = 16'($urandom); t.pos_y = 16'($urandom); t.pos_z = 16'($urandom);
    t.corner_a = 10'($urandom); t.corner_b = 10'($urandom); t.corner_c = 10'($urandom);
    return t;
  endfunction

  function automatic int pick_written(int lim);
    int v;
    do v = $urandom_range(0, lim - 1); while (!written[v]);
    return v;
  endfunction

  task automatic mesh_item(int lim, int pool, bit gaps);
    vna_pkg::vna_in_t t;
    int r;
    t = rand_item();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      t.req_type = vna_pkg::REQ_LOAD;
      t.vertex_index = 10'($urandom_range(0, pool - 1));
      if ($urandom_range(0, 5) == 0) t.pos_x = 16'sh7fff;
      if ($urandom_range(0, 5) == 0) t.pos_y = 16'sh8000;
    end else if (r < 65) begin
      t.req_type = vna_pkg::REQ_TRI;
      t.corner_a = 10'(pick_written(pool));
      t.corner_b = 10'(pick_written(pool));
      t.corner_c = 10'(pick_written(pool));
      if ($urandom_range(0, 19) == 0) t.corner_c = 10'($urandom);
    end else if (r < 93) begin
      t.req_type = vna_pkg::REQ_READ;
      t.vertex_index = 10'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, pool - 1));
    end else if (r < 95) begin
      t.req_type = vna_pkg::REQ_CLEAR;
    end else begin
      t.req_type = vna_pkg::REQ_LOAD;
      t.vertex_index = 10'($urandom);
    end
    if (t.req_type == vna_pkg::REQ_TRI && t.corner_c < lim && !written[t.corner_c])
      t.corner_c = t.corner_a;
    if (t.req_type == vna_pkg::REQ_LOAD && t.vertex_index < lim) written[t.vertex_index] = 1;
    send(t, gaps);
  endtask

  initial begin
    vna_pkg::vna_in_t t;
    int lim;
    board = new();
    for (int i = 0; i < 1024; i++) written[i] = 0;
    hold_off = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed
    t = '0;
    t.req_type = vna_pkg::REQ_READ; t.vertex_index = 0; send(t, 0);
    t.req_type = vna_pkg::REQ_LOAD; t.vertex_index = 0;
    t.pos_x = 16'sh8000; t.pos_y = 16'sh8000; t.pos_z = 16'sh8000; send(t, 0);
    t.vertex_index = 1; t.pos_x = 16'sh7fff; t.pos_y = 16'sh8000; t.pos_z = 16'sh8000;
    send(t, 0);
    t.vertex_index = 2; t.pos_x = 16'sh8000; t.pos_y = 16'sh7fff; t.pos_z = 16'sh7fff;
    send(t, 0);
    t.vertex_index = 1023; t.pos_x = 16'sh0001; t.pos_y = 16'shffff; t.pos_z = 0;
    send(t, 0);
    t.req_type = vna_pkg::REQ_TRI; t.corner_a = 0; t.corner_b = 1; t.corner_c = 2;
    for (int i = 0; i < 6; i++) send(t, 0);
    t.corner_a = 0; t.corner_b = 0; t.corner_c = 1023; send(t, 0);
    t.req_type = vna_pkg::REQ_READ;
    for (int i = 0; i < 3; i++) begin t.vertex_index = 10'(i); send(t, 0); end
    t.vertex_index = 1023; send(t, 0);
    t.req_type = vna_pkg::REQ_CLEAR; t.vertex_index = 1023; send(t, 0);
    t.req_type = vna_pkg::REQ_READ; send(t, 0);
    for (int i = 0; i < 1024; i++) written[i] = i < 3 || i == 1023;

    set_count(3);
    t.req_type = vna_pkg::REQ_LOAD; t.vertex_index = 3; send(t, 0);
    t.req_type = vna_pkg::REQ_TRI; t.corner_a = 0; t.corner_b = 1; t.corner_c = 3; send(t, 0);
    t.corner_a = 1023; send(t, 0);
    t.req_type = vna_pkg::REQ_READ; t.vertex_index = 2; send(t, 0);
    set_count(0);
    t.vertex_index = 0; send(t, 0);
    set_count(2047);
    t.vertex_index = 1023; send(t, 0);

    // random phases
    random_stall = 1;
    for (int ph = 0; ph < 4; ph++) begin
      lim = ph == 0 ? 1024 : ph == 1 ? 3 : ph == 2 ? 40 : 1024;
      set_count(ph == 1 ? 3 : ph == 2 ? 40 : 1024);
      for (int i = 0; i < 1024; i++) if (i >= lim) written[i] = 0;
      for (int i = 0; i < 3; i++) if (!written[i]) begin
        t = rand_item(); t.req_type = vna_pkg::REQ_LOAD; t.vertex_index = 10'(i); send(t, 1);
        written[i] = 1;
      end
      if (ph == 3) hold_off = 1;
      for (int i = 0; i < 260; i++) begin
        mesh_item(lim, lim > 24 ? 24 : lim, ph != 3 || i > 60 ? (i % 80) < 60 : 0);
        if (i == 130) drain();
      end
    end

    drain();
    if (board.error_count == 0) $display("vertex_normal_accumulator_tb: clean");
    else $display("vertex_normal_accumulator_tb: errors");
    $finish;
  end
endmodule

[vertex_normal_accumulator.f]
+incdir+design
design/vna_pkg.sv
design/vna_isqrt.sv
design/vna_div.sv
design/vna_normalize.sv
design/vertex_normal_accumulator.sv
sim/vertex_normal_accumulator_tb.sv
